[src/grid_advection_bilinear_unit_defines.svh]
// ============================================================================
// Assertion macros for the grid advection unit
// Shared assertion forms; every use samples on clk and is held off in reset.
// ============================================================================
`ifndef GRID_ADVECTION_BILINEAR_UNIT_DEFINES_SVH
`define GRID_ADVECTION_BILINEAR_UNIT_DEFINES_SVH

// Same-cycle implication: when cond holds, prop must hold.
`define GAB_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define GAB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[src/gab_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// gab_pkg
// Types, widths and arithmetic helpers shared by the grid advection unit.
// ============================================================================
package gab_pkg;

    // Grid geometry; the stores are split into four banks by row and column parity.
    localparam int GRID_SIDE   = 64;
    localparam int IDX_W       = $clog2(GRID_SIDE);
    localparam int SIDE_W      = IDX_W + 1;
    localparam int NUM_BANKS   = 4;
    localparam int BANK_DEPTH  = GRID_SIDE * GRID_SIDE / NUM_BANKS;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(GRID_SIDE);

    // Data widths.
    localparam int VAL_W   = 32;
    localparam int TS_W    = 16;
    localparam int GIU_W   = 7;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = VAL_W + TS_W + 1;  // velocity times time step
    localparam int POS_W   = 42;                // traced position, Q26.16
    localparam int CELL_W  = POS_W - 16;        // integer part of a position
    localparam int FRAC_W  = 17;                // fraction in (-1, 1)
    localparam int WGT_W   = 18;                // one axis weight in (-1, 2)
    localparam int WPROD_W = 2 * WGT_W;
    localparam int W_W     = 20;                // combined weight after shift
    localparam int TERM_W  = W_W + VAL_W;

    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;

    // Input queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_ADVECT = 1'b1
    } op_t;

    typedef enum logic {
        REG_TIME_STEP   = 1'b0,
        REG_GRID_IN_USE = 1'b1
    } reg_idx_t;

    // One classified command as held in the queue.
    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [1:0]         wr_bank;
        logic [BANK_AW-1:0] wr_addr;
        logic [VAL_W-1:0]   vx;
        logic [VAL_W-1:0]   vy;
        logic [VAL_W-1:0]   q;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef struct packed {
        logic [TS_W-1:0]   time_step;
        logic [SIDE_W-1:0] side;
    } cfg_t;

    // Arithmetic right shift that truncates toward zero.
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< s) - 64'sd1) : 64'sd0;
        return (v + bias) >>> s;
    endfunction

    // Saturate to signed 32 bits.
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/gab_bank_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// gab_bank_ram
// One grid bank: one write port and one registered read port.
// ============================================================================
module gab_bank_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port returns the old word on a same-address write.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/gab_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// gab_front
// Accepts command beats, classifies them and holds them in a short queue.
// ============================================================================
`include "grid_advection_bilinear_unit_defines.svh"

module gab_front
    import gab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [IDX_W-1:0] cell_row,
    input  logic [IDX_W-1:0] cell_col,
    input  logic [VAL_W-1:0] velocity_x,
    input  logic [VAL_W-1:0] velocity_y,
    input  logic [VAL_W-1:0] quantity,
    input  logic             pop,
    output head_t            head
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    cmd_t              incoming;

    assign busy = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;

    // Classify the beat: operation and the bank that owns the cell.
    always_comb
    begin
        incoming.op      = op_t'(opcode);
        incoming.row     = cell_row;
        incoming.col     = cell_col;
        incoming.wr_bank = {cell_row[0], cell_col[0]};
        incoming.wr_addr = {cell_row[IDX_W-1:1], cell_col[IDX_W-1:1]};
        incoming.vx      = velocity_x;
        incoming.vy      = velocity_y;
        incoming.q       = quantity;
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = queue_reg[rd_ptr_reg];

    `GAB_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0, "queue popped while empty")
    `GAB_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count lost a beat")
    `GAB_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH),
        "queue count beyond its depth")

endmodule

[src/gab_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// gab_back
// Executes queued commands: bank writes, and the advect pipeline that samples
// velocity, traces back and samples the quantity.
// ============================================================================
`include "grid_advection_bilinear_unit_defines.svh"

module gab_back
    import gab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  head_t            head,
    output logic             pop,
    output logic             done,
    output logic [IDX_W-1:0] out_row,
    output logic [IDX_W-1:0] out_col,
    output logic [VAL_W-1:0] new_value
);

    // Issue control.
    logic adv_ahead;
    logic issue_adv;
    logic issue_wr;

    // Bank ports.
    logic [BANK_AW-1:0]   vel_raddr [NUM_BANKS];
    logic [2*VAL_W-1:0]   vel_rdata [NUM_BANKS];
    logic [BANK_AW-1:0]   q_raddr   [NUM_BANKS];
    logic [VAL_W-1:0]     q_rdata   [NUM_BANKS];
    logic [NUM_BANKS-1:0] vel_ok;
    logic [NUM_BANKS-1:0] q_ok;
    logic [NUM_BANKS-1:0] bank_we;

    // Pipeline registers.
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                      s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic [IDX_W-1:0]          s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;
    logic [IDX_W-1:0]          s5_row_reg, s6_row_reg, s7_row_reg;
    logic [IDX_W-1:0]          s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    logic [IDX_W-1:0]          s5_col_reg, s6_col_reg, s7_col_reg;
    logic [NUM_BANKS-1:0]      s1_ok_reg, s6_ok_reg;
    logic signed [VAL_W-1:0]   s2_vx_reg, s2_vy_reg, s2_vx_next, s2_vy_next;
    logic signed [PROD_W-1:0]  s3_px_reg, s3_py_reg, s3_px_next, s3_py_next;
    logic signed [POS_W-1:0]   s4_px_reg, s4_py_reg, s4_px_next, s4_py_next;
    logic signed [CELL_W-1:0]  s5_ri_reg, s5_ci_reg, s5_ri_next, s5_ci_next;
    logic signed [FRAC_W-1:0]  s5_fr_reg, s5_fc_reg, s5_fr_next, s5_fc_next;
    logic signed [W_W-1:0]     s6_w_reg [NUM_BANKS];
    logic signed [W_W-1:0]     s6_w_next [NUM_BANKS];
    logic signed [TERM_W-1:0]  s7_term_reg [NUM_BANKS];
    logic signed [TERM_W-1:0]  s7_term_next [NUM_BANKS];
    logic                      done_reg;
    logic [IDX_W-1:0]          out_row_reg, out_col_reg;
    logic signed [VAL_W-1:0]   new_value_reg, new_value_next;

    // A write waits until every earlier advect has read its quantity neighbors.
    assign adv_ahead = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;
    assign issue_adv = head.valid && (head.cmd.op == OP_ADVECT);
    assign issue_wr  = head.valid && (head.cmd.op == OP_WRITE) && !adv_ahead;
    assign pop       = issue_adv || issue_wr;

    // Per-bank neighbor selection and the bank memories.
    for (genvar k = 0; k < NUM_BANKS; k++)
    begin : g_bank
        localparam logic PR = 1'(k / 2);
        localparam logic PC = 1'(k % 2);

        logic [SIDE_W-1:0]        vr, vc;
        logic signed [CELL_W-1:0] qr, qc;
        logic signed [WGT_W-1:0]  wr, wc;
        logic signed [WPROD_W-1:0] wprod;

        // Velocity neighbors of the cell center: this cell and the next row/col.
        assign vr = (head.cmd.row[0] == PR) ? SIDE_W'(head.cmd.row)
                                            : SIDE_W'(head.cmd.row) + 1'b1;
        assign vc = (head.cmd.col[0] == PC) ? SIDE_W'(head.cmd.col)
                                            : SIDE_W'(head.cmd.col) + 1'b1;
        assign vel_ok[k]    = (vr < cfg.side) && (vc < cfg.side);
        assign vel_raddr[k] = {vr[IDX_W-1:1], vc[IDX_W-1:1]};
        assign bank_we[k]   = issue_wr && (head.cmd.wr_bank == 2'(k));

        // Quantity neighbors of the traced point.
        assign qr = (s5_ri_reg[0] == PR) ? s5_ri_reg : s5_ri_reg + 1'b1;
        assign qc = (s5_ci_reg[0] == PC) ? s5_ci_reg : s5_ci_reg + 1'b1;
        assign q_ok[k] = !qr[CELL_W-1] && !qc[CELL_W-1]
                         && (qr < CELL_W'(cfg.side)) && (qc < CELL_W'(cfg.side));
        assign q_raddr[k] = {qr[IDX_W-1:1], qc[IDX_W-1:1]};

        // Bilinear weight of this neighbor.
        assign wr = (s5_ri_reg[0] == PR) ? WGT_W'(ONE_Q16) - WGT_W'(s5_fr_reg)
                                         : WGT_W'(s5_fr_reg);
        assign wc = (s5_ci_reg[0] == PC) ? WGT_W'(ONE_Q16) - WGT_W'(s5_fc_reg)
                                         : WGT_W'(s5_fc_reg);
        assign wprod        = WPROD_W'(wr) * WPROD_W'(wc);
        assign s6_w_next[k] = W_W'(shr_trunc(64'(wprod), 16));

        // Weight times quantity; neighbors outside the grid count as zero.
        assign s7_term_next[k] = s6_ok_reg[k]
            ? TERM_W'(s6_w_reg[k]) * TERM_W'($signed(q_rdata[k]))
            : '0;

        gab_bank_ram #(
            .WIDTH (2 * VAL_W),
            .DEPTH (BANK_DEPTH)
        ) u_vel_ram (
            .clk   (clk),
            .we    (bank_we[k]),
            .waddr (head.cmd.wr_addr),
            .wdata ({head.cmd.vx, head.cmd.vy}),
            .raddr (vel_raddr[k]),
            .rdata (vel_rdata[k])
        );

        gab_bank_ram #(
            .WIDTH (VAL_W),
            .DEPTH (BANK_DEPTH)
        ) u_q_ram (
            .clk   (clk),
            .we    (bank_we[k]),
            .waddr (head.cmd.wr_addr),
            .wdata (head.cmd.q),
            .raddr (q_raddr[k]),
            .rdata (q_rdata[k])
        );
    end

    // Stage 1: velocity at the center, each neighbor weighted by one quarter.
    always_comb
    begin
        logic signed [63:0] vx_acc;
        logic signed [63:0] vy_acc;
        vx_acc = '0;
        vy_acc = '0;
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            if (s1_ok_reg[k])
            begin
                vx_acc = vx_acc + shr_trunc(64'($signed(vel_rdata[k][2*VAL_W-1:VAL_W])), 2);
                vy_acc = vy_acc + shr_trunc(64'($signed(vel_rdata[k][VAL_W-1:0])), 2);
            end
        end
        s2_vx_next = sat32(vx_acc);
        s2_vy_next = sat32(vy_acc);
    end

    // Stage 2: displacement product.
    assign s3_px_next = PROD_W'(s2_vx_reg) * PROD_W'($signed({1'b0, cfg.time_step}));
    assign s3_py_next = PROD_W'(s2_vy_reg) * PROD_W'($signed({1'b0, cfg.time_step}));

    // Stage 3: traced point is the center minus the displacement.
    always_comb
    begin
        logic signed [63:0] cx, cy;
        cx = 64'({s3_col_reg, 16'(HALF_Q16)});
        cy = 64'({s3_row_reg, 16'(HALF_Q16)});
        s4_px_next = POS_W'(cx - shr_trunc(64'(s3_px_reg), 8));
        s4_py_next = POS_W'(cy - shr_trunc(64'(s3_py_reg), 8));
    end

    // Stage 4: integer cell and fraction of the traced point.
    always_comb
    begin
        logic signed [63:0] ri, ci;
        ri = shr_trunc(64'(s4_py_reg), 16);
        ci = shr_trunc(64'(s4_px_reg), 16);
        s5_ri_next = CELL_W'(ri);
        s5_ci_next = CELL_W'(ci);
        s5_fr_next = FRAC_W'(64'(s4_py_reg) - (ri <<< 16));
        s5_fc_next = FRAC_W'(64'(s4_px_reg) - (ci <<< 16));
    end

    // Stage 7: sum of the four weighted neighbors.
    always_comb
    begin
        logic signed [63:0] acc;
        acc = '0;
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            acc = acc + shr_trunc(64'(s7_term_reg[k]), 16);
        end
        new_value_next = sat32(acc);
    end

    // Pipeline valid bits and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_adv;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            done_reg     <= s7_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_row_reg    <= head.cmd.row;
        s1_col_reg    <= head.cmd.col;
        s1_ok_reg     <= vel_ok;
        s2_row_reg    <= s1_row_reg;
        s2_col_reg    <= s1_col_reg;
        s2_vx_reg     <= s2_vx_next;
        s2_vy_reg     <= s2_vy_next;
        s3_row_reg    <= s2_row_reg;
        s3_col_reg    <= s2_col_reg;
        s3_px_reg     <= s3_px_next;
        s3_py_reg     <= s3_py_next;
        s4_row_reg    <= s3_row_reg;
        s4_col_reg    <= s3_col_reg;
        s4_px_reg     <= s4_px_next;
        s4_py_reg     <= s4_py_next;
        s5_row_reg    <= s4_row_reg;
        s5_col_reg    <= s4_col_reg;
        s5_ri_reg     <= s5_ri_next;
        s5_ci_reg     <= s5_ci_next;
        s5_fr_reg     <= s5_fr_next;
        s5_fc_reg     <= s5_fc_next;
        s6_row_reg    <= s5_row_reg;
        s6_col_reg    <= s5_col_reg;
        s6_ok_reg     <= q_ok;
        s7_row_reg    <= s6_row_reg;
        s7_col_reg    <= s6_col_reg;
        out_row_reg   <= s7_row_reg;
        out_col_reg   <= s7_col_reg;
        new_value_reg <= new_value_next;
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            s6_w_reg[k]    <= s6_w_next[k];
            s7_term_reg[k] <= s7_term_next[k];
        end
    end

    assign done      = done_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign new_value = new_value_reg;

    `GAB_ASSERT_IMP(a_pop_has_head, pop, head.valid, "command issued from an empty queue")
    `GAB_ASSERT_IMP(a_write_after_reads, bank_we != '0, !adv_ahead,
        "bank write overtook an advect still reading")
    `GAB_ASSERT_IMP(a_result_latency, s5_valid_reg, ##3 done,
        "advect result did not arrive on time")

endmodule

[src/grid_advection_bilinear_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// grid_advection_bilinear_unit
// Semi-Lagrangian advection of one grid cell with bilinear sampling.
// ============================================================================
//
//  Channel   Handshake           Payload
//  --------  ------------------  ----------------------------------------------
//  command   start / busy        opcode, cell_row, cell_col, velocity_x,
//                                velocity_y, quantity
//  result    done (one cycle)    out_row, out_col, new_value
//  config    cfg_we              cfg_index, cfg_data
//
//  Advects issue from the queue head and flow back to back; each result
//  passes the queue, the stage registers s1 to s7 and the done register
//  before it is on the result ports.
//  A write beat issues once no earlier advect is still ahead of its quantity
//  read, so a write right after an advect waits while it is in s1 to s4.
//  busy rises only when the four-beat command queue is full.
//  Reset empties the queue and the pipeline and sets time step and grid side
//  to 13 and 50; grid contents are not cleared. done cannot be held off by the receiver.
//
module grid_advection_bilinear_unit
    import gab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [IDX_W-1:0] cell_row,
    input  logic [IDX_W-1:0] cell_col,
    input  logic [VAL_W-1:0] velocity_x,
    input  logic [VAL_W-1:0] velocity_y,
    input  logic [VAL_W-1:0] quantity,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             done,
    output logic [IDX_W-1:0] out_row,
    output logic [IDX_W-1:0] out_col,
    output logic [VAL_W-1:0] new_value
);

    logic [TS_W-1:0]  time_step_reg, time_step_next;
    logic [GIU_W-1:0] grid_in_use_reg, grid_in_use_next;
    cfg_t             cfg;
    head_t            head;
    logic             pop;

    // Configuration register writes.
    always_comb
    begin
        time_step_next   = time_step_reg;
        grid_in_use_next = grid_in_use_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TIME_STEP:   time_step_next   = cfg_data;
                REG_GRID_IN_USE: grid_in_use_next = cfg_data[GIU_W-1:0];
                default:         time_step_next   = time_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= TS_W'(13);
            grid_in_use_reg <= GIU_W'(50);
        end
        else
        begin
            time_step_reg   <= time_step_next;
            grid_in_use_reg <= grid_in_use_next;
        end
    end

    // Side in use, limited to the store size.
    assign cfg.time_step = time_step_reg;
    assign cfg.side      = (grid_in_use_reg > GIU_W'(SIDE_MAX)) ? SIDE_MAX
                                                                 : SIDE_W'(grid_in_use_reg);

    gab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .velocity_x (velocity_x),
        .velocity_y (velocity_y),
        .quantity   (quantity),
        .pop        (pop),
        .head       (head)
    );

    gab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .out_row   (out_row),
        .out_col   (out_col),
        .new_value (new_value)
    );

endmodule
